// File: design/sdo_pkg.sv
package sdo_pkg;

    localparam int QW   = 32;
    localparam int MulW = QW + 1;
    localparam int ProdW = 2 * MulW;
    localparam int AccW = QW + 3;

    typedef logic signed [QW-1:0]    q_t;
    typedef logic signed [MulW-1:0]  mul_op_t;
    typedef logic signed [ProdW-1:0] wide_t;
    typedef logic signed [AccW-1:0]  acc_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_RUN,
        ST_DONE
    } sdo_state_t;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_CLEAR  = 1'b1;

    localparam int CfgIdxW = 3;
    localparam logic [CfgIdxW-1:0] CFG_NOMINAL_GAIN       = 3'd0;
    localparam logic [CfgIdxW-1:0] CFG_DAMPING_COEFF      = 3'd1;
    localparam logic [CfgIdxW-1:0] CFG_STIFFNESS_COEFF    = 3'd2;
    localparam logic [CfgIdxW-1:0] CFG_OBSERVER_BANDWIDTH = 3'd3;
    localparam logic [CfgIdxW-1:0] CFG_SAMPLE_PERIOD      = 3'd4;

    localparam q_t           RST_NOMINAL_GAIN       = 32'sd65536;
    localparam q_t           RST_DAMPING_COEFF      = 32'sd0;
    localparam q_t           RST_STIFFNESS_COEFF    = 32'sd0;
    localparam logic [30:0]  RST_OBSERVER_BANDWIDTH = 31'd655360;
    localparam logic [31:0]  RST_SAMPLE_PERIOD      = 32'd4294967;

    // 2 * zeta in Q16.16, zeta = 46334
    localparam mul_op_t TWO_ZETA = 33'sd92668;

    localparam q_t Q_MAX = 32'sh7FFF_FFFF;
    localparam q_t Q_MIN = 32'sh8000_0000;

    typedef struct packed {
        q_t          kn;
        q_t          a1;
        q_t          a0;
        logic [30:0] wn;
        logic [31:0] dt;
    } cfg_t;

    typedef struct packed {
        logic busy;
        logic load;
    } core_stat_t;

    function automatic q_t sat32(input wide_t v);
        q_t r;
        if (!v[ProdW-1] && (|v[ProdW-2:QW-1])) begin
            r = Q_MAX;
        end else if (v[ProdW-1] && !(&v[ProdW-2:QW-1])) begin
            r = Q_MIN;
        end else begin
            r = v[QW-1:0];
        end
        return r;
    endfunction

    function automatic acc_t acc_of(input q_t v);
        return {{(AccW-QW){v[QW-1]}}, v};
    endfunction

    function automatic wide_t widen(input acc_t v);
        return {{(ProdW-AccW){v[AccW-1]}}, v};
    endfunction

endpackage

// File: design/second_order_disturbance_observer.sv
// Sample item: eleven passes through the shared multiplier, then the result is loaded into the
// output register once it is free or being taken; the next input transfer follows the load.
// Clear item: no multiplier passes; the load and the next transfer follow in the same way.
// A result waiting in the output register does not block the next input transfer.
// rst_n (asynchronous, active low) zeroes both states and loads register defaults.
module second_order_disturbance_observer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_write,
    input  logic [sdo_pkg::CfgIdxW-1:0]   cfg_index,
    input  logic [31:0]                   cfg_data,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          op,
    input  logic signed [31:0]            control_in,
    input  logic signed [31:0]            measured_out,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [31:0]            disturbance_est,
    output logic signed [31:0]            position_est,
    output logic signed [31:0]            velocity_est
);

    sdo_pkg::cfg_t       cfg_reg;
    sdo_pkg::core_stat_t stat;
    sdo_pkg::q_t         core_dist;
    sdo_pkg::q_t         core_pos;
    sdo_pkg::q_t         core_vel;

    logic        start;
    logic        out_free;
    logic        out_valid_reg;
    sdo_pkg::q_t disturbance_est_reg;
    sdo_pkg::q_t position_est_reg;
    sdo_pkg::q_t velocity_est_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            cfg_reg.kn <= sdo_pkg::RST_NOMINAL_GAIN;
            cfg_reg.a1 <= sdo_pkg::RST_DAMPING_COEFF;
            cfg_reg.a0 <= sdo_pkg::RST_STIFFNESS_COEFF;
            cfg_reg.wn <= sdo_pkg::RST_OBSERVER_BANDWIDTH;
            cfg_reg.dt <= sdo_pkg::RST_SAMPLE_PERIOD;
        end else if (cfg_write) begin
            case (cfg_index)
                sdo_pkg::CFG_NOMINAL_GAIN:       cfg_reg.kn <= cfg_data;
                sdo_pkg::CFG_DAMPING_COEFF:      cfg_reg.a1 <= cfg_data;
                sdo_pkg::CFG_STIFFNESS_COEFF:    cfg_reg.a0 <= cfg_data;
                sdo_pkg::CFG_OBSERVER_BANDWIDTH: cfg_reg.wn <= cfg_data[30:0];
                sdo_pkg::CFG_SAMPLE_PERIOD:      cfg_reg.dt <= cfg_data;
                default:                         cfg_reg    <= cfg_reg;
            endcase
        end
    end

    assign in_stall = stat.busy;
    assign start    = in_valid && !stat.busy;
    assign out_free = !out_valid_reg || !out_stall;

    sdo_core u_core (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg      (cfg_reg),
        .start    (start),
        .op       (op),
        .u        (control_in),
        .y        (measured_out),
        .out_free (out_free),
        .stat     (stat),
        .dist_est (core_dist),
        .pos      (core_pos),
        .vel      (core_vel)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            out_valid_reg <= 1'b0;
        end else if (stat.load) begin
            out_valid_reg <= 1'b1;
        end else if (!out_stall) begin
            // drop the result once transferred
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (stat.load) begin
            disturbance_est_reg <= core_dist;
            position_est_reg    <= core_pos;
            velocity_est_reg    <= core_vel;
        end
    end

    assign out_valid       = out_valid_reg;
    assign disturbance_est = disturbance_est_reg;
    assign position_est    = position_est_reg;
    assign velocity_est    = velocity_est_reg;

endmodule

// File: design/sdo_mul.sv
module sdo_mul (
    input  logic             clk,
    input  sdo_pkg::mul_op_t a,
    input  sdo_pkg::mul_op_t b,
    input  logic             dt_shift,
    output sdo_pkg::q_t      result
);

    sdo_pkg::wide_t product;
    sdo_pkg::wide_t product_reg;
    sdo_pkg::wide_t shifted;
    logic           dt_shift_reg;

    assign product = a * b;

    always_ff @(posedge clk)
    begin
        product_reg  <= product;
        dt_shift_reg <= dt_shift;
    end

    // floor shift: Q16.16 products drop 16 bits, products with Q0.32 dt drop 32
    always_comb
    begin
        if (dt_shift_reg) begin
            shifted = product_reg >>> 32;
        end else begin
            shifted = product_reg >>> 16;
        end
    end

    assign result = sdo_pkg::sat32(shifted);

endmodule

// File: design/sdo_core.sv
module sdo_core (
    input  logic                 clk,
    input  logic                 rst_n,
    input  sdo_pkg::cfg_t        cfg,
    input  logic                 start,
    input  logic                 op,
    input  sdo_pkg::q_t          u,
    input  sdo_pkg::q_t          y,
    input  logic                 out_free,
    output sdo_pkg::core_stat_t  stat,
    output sdo_pkg::q_t          dist_est,
    output sdo_pkg::q_t          pos,
    output sdo_pkg::q_t          vel
);

    // Step s issues multiply s and consumes the product issued at step s-1.
    localparam logic [3:0] STEP_L1     = 4'd0;
    localparam logic [3:0] STEP_L2     = 4'd1;
    localparam logic [3:0] STEP_A0X1   = 4'd2;
    localparam logic [3:0] STEP_A1X2   = 4'd3;
    localparam logic [3:0] STEP_KNU    = 4'd4;
    localparam logic [3:0] STEP_L1E    = 4'd5;
    localparam logic [3:0] STEP_L2E    = 4'd6;
    localparam logic [3:0] STEP_DX1DT  = 4'd7;
    localparam logic [3:0] STEP_DX2DT  = 4'd8;
    localparam logic [3:0] STEP_A0X1N  = 4'd9;
    localparam logic [3:0] STEP_A1X2N  = 4'd10;
    localparam logic [3:0] STEP_LAST   = 4'd11;

    sdo_pkg::sdo_state_t state_reg;
    sdo_pkg::sdo_state_t state_next;
    logic [3:0]          step_reg;
    logic [3:0]          step_next;

    sdo_pkg::q_t  pos_reg;
    sdo_pkg::q_t  vel_reg;
    sdo_pkg::q_t  e_reg;
    sdo_pkg::q_t  u_reg;
    sdo_pkg::q_t  l1_reg;
    sdo_pkg::q_t  l2_reg;
    sdo_pkg::q_t  knu_reg;
    sdo_pkg::q_t  dx1_reg;
    sdo_pkg::q_t  dx2_reg;
    sdo_pkg::q_t  dist_reg;
    sdo_pkg::acc_t acc_reg;

    sdo_pkg::mul_op_t mul_a;
    sdo_pkg::mul_op_t mul_b;
    logic             mul_dt;
    sdo_pkg::q_t      p;

    sdo_pkg::acc_t add_a;
    sdo_pkg::acc_t add_b;
    sdo_pkg::acc_t sum;
    sdo_pkg::q_t   sum_sat;

    logic run;

    assign run = (state_reg == sdo_pkg::ST_RUN);

    sdo_mul u_mul (
        .clk      (clk),
        .a        (mul_a),
        .b        (mul_b),
        .dt_shift (mul_dt),
        .result   (p)
    );

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a  = '0;
        mul_b  = '0;
        mul_dt = 1'b0;
        case (step_reg)
            STEP_L1:
            begin
                mul_a = sdo_pkg::TWO_ZETA;
                mul_b = {2'b00, cfg.wn};
            end
            STEP_L2:
            begin
                mul_a = {2'b00, cfg.wn};
                mul_b = {2'b00, cfg.wn};
            end
            STEP_A0X1, STEP_A0X1N:
            begin
                mul_a = {cfg.a0[31], cfg.a0};
                mul_b = {pos_reg[31], pos_reg};
            end
            STEP_A1X2, STEP_A1X2N:
            begin
                mul_a = {cfg.a1[31], cfg.a1};
                mul_b = {vel_reg[31], vel_reg};
            end
            STEP_KNU:
            begin
                mul_a = {cfg.kn[31], cfg.kn};
                mul_b = {u_reg[31], u_reg};
            end
            STEP_L1E:
            begin
                mul_a = {l1_reg[31], l1_reg};
                mul_b = {e_reg[31], e_reg};
            end
            STEP_L2E:
            begin
                mul_a = {l2_reg[31], l2_reg};
                mul_b = {e_reg[31], e_reg};
            end
            STEP_DX1DT:
            begin
                mul_a  = {dx1_reg[31], dx1_reg};
                mul_b  = {1'b0, cfg.dt};
                mul_dt = 1'b1;
            end
            STEP_DX2DT:
            begin
                mul_a  = {dx2_reg[31], dx2_reg};
                mul_b  = {1'b0, cfg.dt};
                mul_dt = 1'b1;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // shared adder: error term while idle, sums of products while running
    always_comb
    begin
        add_a = sdo_pkg::acc_of(y);
        add_b = -sdo_pkg::acc_of(pos_reg);
        if (run) begin
            case (step_reg)
                STEP_A1X2:
                begin
                    add_a = '0;
                    add_b = -sdo_pkg::acc_of(p);
                end
                STEP_KNU:
                begin
                    add_a = acc_reg;
                    add_b = -sdo_pkg::acc_of(p);
                end
                STEP_L2E:
                begin
                    add_a = sdo_pkg::acc_of(vel_reg);
                    add_b = sdo_pkg::acc_of(p);
                end
                STEP_DX2DT:
                begin
                    add_a = sdo_pkg::acc_of(pos_reg);
                    add_b = sdo_pkg::acc_of(p);
                end
                STEP_A0X1N:
                begin
                    add_a = sdo_pkg::acc_of(vel_reg);
                    add_b = sdo_pkg::acc_of(p);
                end
                default:
                begin
                    add_a = acc_reg;
                    add_b = sdo_pkg::acc_of(p);
                end
            endcase
        end
    end

    assign sum     = add_a + add_b;
    assign sum_sat = sdo_pkg::sat32(sdo_pkg::widen(sum));

    // next state
    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        case (state_reg)
            sdo_pkg::ST_IDLE:
            begin
                if (start) begin
                    step_next = STEP_L1;
                    if (op == sdo_pkg::OP_CLEAR) begin
                        state_next = sdo_pkg::ST_DONE;
                    end else begin
                        state_next = sdo_pkg::ST_RUN;
                    end
                end
            end
            sdo_pkg::ST_RUN:
            begin
                if (step_reg == STEP_LAST) begin
                    state_next = sdo_pkg::ST_DONE;
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            sdo_pkg::ST_DONE:
            begin
                if (out_free) begin
                    state_next = sdo_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = sdo_pkg::ST_IDLE;
            end
        endcase
    end

    // outputs
    always_comb
    begin
        stat.busy = 1'b1;
        stat.load = 1'b0;
        case (state_reg)
            sdo_pkg::ST_IDLE:
            begin
                stat.busy = 1'b0;
            end
            sdo_pkg::ST_DONE:
            begin
                stat.load = out_free;
            end
            default:
            begin
                stat.busy = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= sdo_pkg::ST_IDLE;
            step_reg  <= STEP_L1;
            pos_reg   <= '0;
            vel_reg   <= '0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            if (start && (op == sdo_pkg::OP_CLEAR)) begin
                pos_reg <= '0;
                vel_reg <= '0;
            end else if (run && (step_reg == STEP_DX2DT)) begin
                pos_reg <= sum_sat;
            end else if (run && (step_reg == STEP_A0X1N)) begin
                vel_reg <= sum_sat;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start) begin
            e_reg <= sum_sat;
            u_reg <= u;
            if (op == sdo_pkg::OP_CLEAR) begin
                dist_reg <= '0;
            end
        end
        if (run) begin
            case (step_reg)
                STEP_L2:    l1_reg  <= p;
                STEP_A0X1:  l2_reg  <= p;
                STEP_A1X2:  acc_reg <= sum;
                STEP_KNU:   acc_reg <= sum;
                STEP_L1E:
                begin
                    acc_reg <= sum;
                    knu_reg <= p;
                end
                STEP_L2E:   dx1_reg <= sum_sat;
                STEP_DX1DT: dx2_reg <= sum_sat;
                // start the estimate from dx2 - Kn*u
                STEP_DX2DT: acc_reg <= sdo_pkg::acc_of(dx2_reg) - sdo_pkg::acc_of(knu_reg);
                STEP_A1X2N: acc_reg <= sum;
                STEP_LAST:  dist_reg <= sum_sat;
                default:    acc_reg <= acc_reg;
            endcase
        end
    end

    assign dist_est = dist_reg;
    assign pos      = pos_reg;
    assign vel      = vel_reg;

    a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> (state_reg == sdo_pkg::ST_IDLE))
        else $error("item started while sequencer busy");

    a_sample_run: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (op == sdo_pkg::OP_SAMPLE)) |=>
            ((state_reg == sdo_pkg::ST_RUN) && (step_reg == STEP_L1)))
        else $error("sample did not enter run at first step");

    a_clear_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (start && (op == sdo_pkg::OP_CLEAR)) |=>
            ((state_reg == sdo_pkg::ST_DONE) && (pos_reg == '0) && (vel_reg == '0)))
        else $error("clear did not zero states");

    a_step_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (run && (step_reg != STEP_LAST)) |=>
            (run && (step_reg == ($past(step_reg) + 4'd1))))
        else $error("step sequence broken");

    a_step_range: assert property (@(posedge clk) disable iff (!rst_n)
        run |-> (step_reg <= STEP_LAST))
        else $error("step beyond last");

endmodule

// File: tb/tb_second_order_disturbance_observer.sv
module tb_second_order_disturbance_observer;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int     LIMIT       = 1_000_000;
    localparam int     SETTLE      = 20;
    localparam int     NUM_PHASES  = 16;
    localparam int     PHASE_ITEMS = 100;
    localparam int     DIR_ROWS    = 19;
    localparam int     CFG_TOP     = (1 << sdo_pkg::CfgIdxW) - 1;
    localparam longint ZETA_Q      = 46334;
    localparam longint Q_HI        = 64'sd2147483647;
    localparam longint Q_LO        = -64'sd2147483648;

    typedef enum int {
        PICK_LOW,
        PICK_HIGH,
        PICK_TYPICAL,
        PICK_ANY
    } cfg_pick_t;

    typedef struct packed {
        sdo_pkg::q_t dist_est;
        sdo_pkg::q_t pos;
        sdo_pkg::q_t vel;
    } obs_result_t;

    typedef struct packed {
        logic        kind;
        logic [31:0] ctrl;
        logic [31:0] meas;
        logic        typed;
        obs_result_t want;
    } probe_row_t;

    logic                         clk;
    logic                         rst_n;
    logic                         cfg_write;
    logic [sdo_pkg::CfgIdxW-1:0]  cfg_index;
    logic [31:0]                  cfg_data;
    logic                         in_valid;
    logic                         in_stall;
    logic                         op;
    logic signed [31:0]           control_in;
    logic signed [31:0]           measured_out;
    logic                         out_valid;
    logic                         out_stall;
    logic signed [31:0]           disturbance_est;
    logic signed [31:0]           position_est;
    logic signed [31:0]           velocity_est;

    // observer copy: configuration and states
    longint gain_kn;
    longint coef_a1;
    longint coef_a0;
    longint band_wn;
    longint step_dt;
    longint x_pos;
    longint x_vel;

    obs_result_t pending_estimates [$];
    probe_row_t  dir_table [DIR_ROWS];
    int          mismatch_count;
    int          cycle_count;
    logic        quiet;

    second_order_disturbance_observer u_top (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_write       (cfg_write),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .op              (op),
        .control_in      (control_in),
        .measured_out    (measured_out),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .disturbance_est (disturbance_est),
        .position_est    (position_est),
        .velocity_est    (velocity_est)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint clamp32(input longint v);
        if (v > Q_HI)
            return Q_HI;
        if (v < Q_LO)
            return Q_LO;
        return v;
    endfunction

    function automatic longint fix_mul(input longint a, input longint b);
        return clamp32((a * b) >>> 16);
    endfunction

    function automatic longint step_mul(input longint a);
        return (a * step_dt) >>> 32;
    endfunction

    function automatic obs_result_t predict_estimate(input logic kind, input sdo_pkg::q_t u_in,
                                                     input sdo_pkg::q_t y_in);
        longint      u;
        longint      y;
        longint      l1;
        longint      l2;
        longint      e;
        longint      dx1;
        longint      dx2;
        longint      dist_sum;
        obs_result_t r;
        if (kind == sdo_pkg::OP_CLEAR)
        begin
            x_pos = 0;
            x_vel = 0;
            return '0;
        end
        u   = u_in;
        y   = y_in;
        l1  = clamp32((2 * ZETA_Q * band_wn) >>> 16);
        l2  = clamp32((band_wn * band_wn) >>> 16);
        e   = clamp32(y - x_pos);
        dx1 = clamp32(x_vel + fix_mul(l1, e));
        dx2 = clamp32(-fix_mul(coef_a0, x_pos) - fix_mul(coef_a1, x_vel)
                      + fix_mul(gain_kn, u) + fix_mul(l2, e));
        x_pos = clamp32(x_pos + step_mul(dx1));
        x_vel = clamp32(x_vel + step_mul(dx2));
        // disturbance uses the advanced states
        dist_sum = clamp32(dx2 + fix_mul(coef_a0, x_pos) + fix_mul(coef_a1, x_vel)
                           - fix_mul(gain_kn, u));
        r.dist_est = dist_sum[31:0];
        r.pos      = x_pos[31:0];
        r.vel      = x_vel[31:0];
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (quiet)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 85)
            return $urandom_range(1, 3);
        if (r < 97)
            return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [31:0] pick_signal();
        int k;
        k = $urandom_range(0, 9);
        if (k == 0)
        begin
            case ($urandom_range(0, 3))
                0:       return 32'h8000_0000;
                1:       return 32'h7FFF_FFFF;
                2:       return 32'h0000_0000;
                default: return 32'hFFFF_FFFF;
            endcase
        end
        if (k <= 2)
            return $urandom;
        return $urandom_range(0, 32 << 16) - (16 << 16);
    endfunction

    function automatic logic [31:0] pick_cfg(input logic [sdo_pkg::CfgIdxW-1:0] idx,
                                             input cfg_pick_t how);
        logic [31:0] v;
        case (how)
            // bit 31 of the bandwidth write is dropped, so this also lands on zero
            PICK_LOW:
                v = (idx == sdo_pkg::CFG_SAMPLE_PERIOD) ? 32'h0 : 32'h8000_0000;
            PICK_HIGH:
                v = (idx == sdo_pkg::CFG_SAMPLE_PERIOD ||
                     idx == sdo_pkg::CFG_OBSERVER_BANDWIDTH) ?
                    32'hFFFF_FFFF : 32'h7FFF_FFFF;
            PICK_TYPICAL:
            begin
                case (idx)
                    sdo_pkg::CFG_NOMINAL_GAIN:
                        v = $urandom_range(0, 8 << 16) - (4 << 16);
                    sdo_pkg::CFG_DAMPING_COEFF, sdo_pkg::CFG_STIFFNESS_COEFF:
                        v = $urandom_range(0, 100 << 16) - (50 << 16);
                    sdo_pkg::CFG_OBSERVER_BANDWIDTH:
                        v = $urandom_range(0, 200 << 16) | ($urandom & 32'h8000_0000);
                    default:
                        v = $urandom_range(0, 42949673);
                endcase
            end
            default:
                v = $urandom;
        endcase
        return v;
    endfunction

    task automatic write_reg(input logic [sdo_pkg::CfgIdxW-1:0] idx, input logic [31:0] data);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        case (idx)
            sdo_pkg::CFG_NOMINAL_GAIN:       gain_kn = longint'($signed(data));
            sdo_pkg::CFG_DAMPING_COEFF:      coef_a1 = longint'($signed(data));
            sdo_pkg::CFG_STIFFNESS_COEFF:    coef_a0 = longint'($signed(data));
            sdo_pkg::CFG_OBSERVER_BANDWIDTH: band_wn = longint'(data[30:0]);
            sdo_pkg::CFG_SAMPLE_PERIOD:      step_dt = longint'(data);
            default: ;
        endcase
    endtask

    task automatic load_settings(input int phase);
        int                          i;
        cfg_pick_t                   how;
        logic [sdo_pkg::CfgIdxW-1:0] idx;
        for (i = 0; i <= CFG_TOP; i++)
        begin
            idx = i[sdo_pkg::CfgIdxW-1:0];
            if (phase == 1)
                how = PICK_LOW;
            else if (phase == 2)
                how = PICK_HIGH;
            else
            begin
                case ($urandom_range(0, 9))
                    0:       how = PICK_LOW;
                    1:       how = PICK_HIGH;
                    8, 9:    how = PICK_ANY;
                    default: how = PICK_TYPICAL;
                endcase
            end
            // unused indexes get random data and must change nothing
            if (idx <= sdo_pkg::CFG_SAMPLE_PERIOD)
                write_reg(idx, pick_cfg(idx, how));
            else
                write_reg(idx, $urandom);
        end
        cfg_write <= 1'b0;
    endtask

    task automatic send_item(input logic kind, input logic [31:0] ctrl,
                             input logic [31:0] meas, input logic typed,
                             input obs_result_t want);
        int          gap;
        obs_result_t guess;
        gap = pick_gap();
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        op           <= kind;
        control_in   <= ctrl;
        measured_out <= meas;
        guess = predict_estimate(kind, ctrl, meas);
        pending_estimates.push_back(typed ? want : guess);
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_estimates.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic flag_error(input string what, input sdo_pkg::q_t want,
                              input sdo_pkg::q_t got);
        if (mismatch_count < 10)
            $display("mismatch: %s expected %0d got %0d", what, want, got);
        mismatch_count++;
    endtask

    task automatic check_estimate();
        obs_result_t want;
        if (pending_estimates.size() == 0)
        begin
            flag_error("result with nothing pending, disturbance_est", 0, disturbance_est);
            return;
        end
        want = pending_estimates.pop_front();
        if (disturbance_est !== want.dist_est)
            flag_error("disturbance_est", want.dist_est, disturbance_est);
        if (position_est !== want.pos)
            flag_error("position_est", want.pos, position_est);
        if (velocity_est !== want.vel)
            flag_error("velocity_est", want.vel, velocity_est);
    endtask

    // shared calm stretches: neither side starts a new idle gap while quiet is set
    initial
    begin
        quiet = 1'b0;
        forever
        begin
            repeat ($urandom_range(100, 400)) @(posedge clk);
            quiet <= ($urandom_range(0, 3) == 0);
        end
    end

    initial
    begin
        int hold;
        hold = 0;
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall)
                check_estimate();
            if (hold > 0)
                hold--;
            else if ($urandom_range(0, 3) == 0)
                hold = pick_gap();
            out_stall <= (hold > 0);
        end
    end

    initial
    begin
        cycle_count = 0;
        while (cycle_count < LIMIT)
        begin
            @(posedge clk);
            cycle_count++;
        end
        $display("tb_second_order_disturbance_observer: done, errors");
        $finish;
    end

    initial
    begin
        int          r;
        int          phase;
        int          n;
        logic        kind;
        logic [31:0] ctrl;
        logic [31:0] meas;

        rst_n          = 1'b0;
        cfg_write      = 1'b0;
        cfg_index      = '0;
        cfg_data       = '0;
        in_valid       = 1'b0;
        op             = sdo_pkg::OP_SAMPLE;
        control_in     = '0;
        measured_out   = '0;
        mismatch_count = 0;
        gain_kn        = sdo_pkg::RST_NOMINAL_GAIN;
        coef_a1        = sdo_pkg::RST_DAMPING_COEFF;
        coef_a0        = sdo_pkg::RST_STIFFNESS_COEFF;
        band_wn        = longint'(sdo_pkg::RST_OBSERVER_BANDWIDTH);
        step_dt        = longint'(sdo_pkg::RST_SAMPLE_PERIOD);
        x_pos          = 0;
        x_vel          = 0;

        // zero rows are exact by inspection; the rest go through the predictor
        dir_table = '{
            '{sdo_pkg::OP_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'h0000_0000, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h8000_0000, 32'h8000_0000, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h7FFF_FFFF, 32'h8000_0000, 1'b0, '0},
            '{sdo_pkg::OP_CLEAR,  32'h7FFF_FFFF, 32'h8000_0000, 1'b1, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h0000_0000, 32'h7FFF_FFFF, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'hFFFF_FFFF, 32'h0000_0001, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h5555_5555, 32'hAAAA_AAAA, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'hAAAA_AAAA, 32'h5555_5555, 1'b0, '0},
            '{sdo_pkg::OP_CLEAR,  32'h8000_0000, 32'h7FFF_FFFF, 1'b1, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h0001_0000, 32'hFFFF_0000, 1'b0, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b0, '0},
            '{sdo_pkg::OP_CLEAR,  32'h0000_0000, 32'h0000_0000, 1'b1, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h0000_0000, 32'h0000_0000, 1'b1, '0},
            '{sdo_pkg::OP_SAMPLE, 32'h8000_0000, 32'h7FFF_FFFF, 1'b0, '0}
        };

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (r = 0; r < DIR_ROWS; r++)
            send_item(dir_table[r].kind, dir_table[r].ctrl, dir_table[r].meas,
                      dir_table[r].typed, dir_table[r].want);

        for (phase = 0; phase < NUM_PHASES; phase++)
        begin
            // hold input until every estimate has come back, then reprogram
            if (phase != 0)
            begin
                drain_results();
                load_settings(phase);
            end
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                kind = ($urandom_range(0, 99) < 5) ? sdo_pkg::OP_CLEAR : sdo_pkg::OP_SAMPLE;
                ctrl = pick_signal();
                meas = pick_signal();
                send_item(kind, ctrl, meas, 1'b0, '0);
            end
        end

        drain_results();
        if (mismatch_count == 0)
            $display("tb_second_order_disturbance_observer: done, clean");
        else
            $display("tb_second_order_disturbance_observer: done, errors");
        $finish;
    end

endmodule
